// ----- src/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define OWM_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("onewire master assertion failed");

// same, on the default clk_i / rst_ni pair
`define OWM_ASSERT(name, prop) `OWM_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

// ----- src/owm_pkg.sv -----
package owm_pkg;

  localparam int unsigned TickW   = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TickW-1:0] tick_t;

  // fixed read slot timing
  localparam tick_t READ_LOW_TICKS    = tick_t'(5);
  localparam tick_t READ_SAMPLE_TICKS = tick_t'(5);

  // register reset values
  localparam tick_t REST_RST       = tick_t'(2000);
  localparam tick_t RST_LOW_RST    = tick_t'(1000);
  localparam tick_t PRES_WAIT_RST  = tick_t'(30);
  localparam tick_t PRES_END_RST   = tick_t'(1000);
  localparam tick_t WR_ONE_RST     = tick_t'(8);
  localparam tick_t WR_ZERO_RST    = tick_t'(90);
  localparam tick_t WR_REC_RST     = tick_t'(10);
  localparam tick_t RD_REC_RST     = tick_t'(100);

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PRESENT     = 2'd0,
    ST_STUCK_LOW   = 2'd1,
    ST_NO_PRESENCE = 2'd2,
    ST_NOT_ENDED   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REST      = 3'd0,
    REG_RST_LOW   = 3'd1,
    REG_PRES_WAIT = 3'd2,
    REG_PRES_END  = 3'd3,
    REG_WR_ONE    = 3'd4,
    REG_WR_ZERO   = 3'd5,
    REG_WR_REC    = 3'd6,
    REG_RD_REC    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    tick_t rest_ticks;
    tick_t reset_low_ticks;
    tick_t presence_wait_ticks;
    tick_t presence_end_ticks;
    tick_t write_one_low_ticks;
    tick_t write_zero_low_ticks;
    tick_t write_recovery_ticks;
    tick_t read_recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [1:0]       presence_status;
    logic [ByteW-1:0] read_data;
  } res_t;

endpackage

// ----- src/owm_if.sv -----
interface owm_in_if;
  import owm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [ByteW-1:0] data_byte;
  logic             line_level;

  modport source (output valid, command, data_byte, line_level, input ready);
  modport sink   (input valid, command, data_byte, line_level, output ready);
endinterface

interface owm_out_if;
  import owm_pkg::*;
  logic             valid;
  logic             ready;
  logic             drive_low;
  logic             busy_res;
  logic             done_res;
  logic [1:0]       presence_status;
  logic [ByteW-1:0] read_data;

  modport source (output valid, drive_low, busy_res, done_res, presence_status, read_data,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence_status, read_data,
                  output ready);
endinterface

// ----- src/owm_cfg.sv -----
module owm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [owm_pkg::TickW-1:0]       cfg_data_i,
  output owm_pkg::cfg_t                   cfg_o
);
  import owm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_REST:      cfg_d.rest_ticks           = cfg_data_i;
        REG_RST_LOW:   cfg_d.reset_low_ticks      = cfg_data_i;
        REG_PRES_WAIT: cfg_d.presence_wait_ticks  = cfg_data_i;
        REG_PRES_END:  cfg_d.presence_end_ticks   = cfg_data_i;
        REG_WR_ONE:    cfg_d.write_one_low_ticks  = cfg_data_i;
        REG_WR_ZERO:   cfg_d.write_zero_low_ticks = cfg_data_i;
        REG_WR_REC:    cfg_d.write_recovery_ticks = cfg_data_i;
        REG_RD_REC:    cfg_d.read_recovery_ticks  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_ticks           <= REST_RST;
      cfg_q.reset_low_ticks      <= RST_LOW_RST;
      cfg_q.presence_wait_ticks  <= PRES_WAIT_RST;
      cfg_q.presence_end_ticks   <= PRES_END_RST;
      cfg_q.write_one_low_ticks  <= WR_ONE_RST;
      cfg_q.write_zero_low_ticks <= WR_ZERO_RST;
      cfg_q.write_recovery_ticks <= WR_REC_RST;
      cfg_q.read_recovery_ticks  <= RD_REC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/owm_core.sv -----
module owm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [1:0]                  command_i,
  input  logic [owm_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        line_level_i,
  input  owm_pkg::cfg_t               cfg_i,
  output owm_pkg::res_t               res_o
);
  import owm_pkg::*;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_REST      = 10'b00_0000_0010,
    PH_RST_LOW   = 10'b00_0000_0100,
    PH_PRES_WAIT = 10'b00_0000_1000,
    PH_PRES_END  = 10'b00_0001_0000,
    PH_WR_LOW    = 10'b00_0010_0000,
    PH_WR_REC    = 10'b00_0100_0000,
    PH_RD_LOW    = 10'b00_1000_0000,
    PH_RD_WAIT   = 10'b01_0000_0000,
    PH_RD_REC    = 10'b10_0000_0000
  } phase_e;

  phase_e               phase_q, phase_d, phase_c;
  tick_t                tick_q, tick_d, tick_c, tick_n;
  tick_t                len_raw, len;
  logic [BitIdxW-1:0]   bit_q, bit_d, bit_c;
  logic [ByteW-1:0]     shift_q, shift_d, shift_c;
  logic [1:0]           status_q, status_d;
  logic [ByteW-1:0]     rdata_q, rdata_d;
  logic                 start, drive, done;

  always_comb begin
    // command pickup in idle, effective on this same tick
    start   = (phase_q == PH_IDLE) && (cmd_e'(command_i) != CMD_NONE);
    phase_c = phase_q;
    tick_c  = tick_q;
    bit_c   = bit_q;
    shift_c = shift_q;
    if (start) begin
      bit_c  = '0;
      tick_c = '0;
      unique case (cmd_e'(command_i))
        CMD_RESET: phase_c = PH_REST;
        CMD_WRITE: begin
          phase_c = PH_WR_LOW;
          shift_c = data_byte_i;
        end
        CMD_READ: begin
          phase_c = PH_RD_LOW;
          shift_c = '0;
        end
        default: phase_c = phase_q;
      endcase
    end

    unique case (phase_c)
      PH_REST:      len_raw = cfg_i.rest_ticks;
      PH_RST_LOW:   len_raw = cfg_i.reset_low_ticks;
      PH_PRES_WAIT: len_raw = cfg_i.presence_wait_ticks;
      PH_PRES_END:  len_raw = cfg_i.presence_end_ticks;
      PH_WR_LOW:    len_raw = shift_c[0] ? cfg_i.write_one_low_ticks
                                         : cfg_i.write_zero_low_ticks;
      PH_WR_REC:    len_raw = cfg_i.write_recovery_ticks;
      PH_RD_LOW:    len_raw = READ_LOW_TICKS;
      PH_RD_WAIT:   len_raw = READ_SAMPLE_TICKS;
      PH_RD_REC:    len_raw = cfg_i.read_recovery_ticks;
      default:      len_raw = tick_t'(1);
    endcase
    // zero length behaves as a single tick
    len = (len_raw == '0) ? tick_t'(1) : len_raw;

    tick_n   = tick_c + tick_t'(1);
    phase_d  = phase_c;
    tick_d   = tick_c;
    bit_d    = bit_c;
    shift_d  = shift_c;
    status_d = status_q;
    rdata_d  = rdata_q;
    drive    = 1'b0;
    done     = 1'b0;

    if (phase_c != PH_IDLE) begin
      drive  = (phase_c == PH_RST_LOW) || (phase_c == PH_WR_LOW) || (phase_c == PH_RD_LOW);
      tick_d = tick_n;
      if (tick_n >= len) begin
        tick_d = '0;
        unique case (phase_c)
          PH_REST: begin
            if (!line_level_i) begin
              status_d = ST_STUCK_LOW;
              done     = 1'b1;
            end else begin
              phase_d = PH_RST_LOW;
            end
          end
          PH_RST_LOW: phase_d = PH_PRES_WAIT;
          PH_PRES_WAIT: begin
            if (line_level_i) begin
              status_d = ST_NO_PRESENCE;
              done     = 1'b1;
            end else begin
              phase_d = PH_PRES_END;
            end
          end
          PH_PRES_END: begin
            status_d = line_level_i ? ST_PRESENT : ST_NOT_ENDED;
            done     = 1'b1;
          end
          PH_WR_LOW: phase_d = PH_WR_REC;
          PH_WR_REC: begin
            if (bit_c == '1) begin
              done = 1'b1;
            end else begin
              shift_d = {1'b0, shift_c[ByteW-1:1]};
              bit_d   = bit_c + BitIdxW'(1);
              phase_d = PH_WR_LOW;
            end
          end
          PH_RD_LOW: phase_d = PH_RD_WAIT;
          PH_RD_WAIT: begin
            // bits arrive lsb first, so shift in from the top
            shift_d = {line_level_i, shift_c[ByteW-1:1]};
            phase_d = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (bit_c == '1) begin
              rdata_d = shift_c;
              done    = 1'b1;
            end else begin
              bit_d   = bit_c + BitIdxW'(1);
              phase_d = PH_RD_LOW;
            end
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          phase_d = PH_IDLE;
        end
      end
    end

    res_o.drive_low       = drive;
    res_o.busy_res        = (phase_d != PH_IDLE);
    res_o.done_res        = done;
    res_o.presence_status = status_d;
    res_o.read_data       = rdata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      status_q <= '0;
      rdata_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      status_q <= status_d;
      rdata_q  <= rdata_d;
    end
  end

endmodule

// ----- src/onewire_master.sv -----
// timed 1-wire bus master
// in_if carries one request per microsecond tick: the sampled bus level and an
//   optional command (reset with presence check, write byte, read byte; lsb first)
// out_if returns one result per request: drive_low for the open-drain pad,
//   busy/done flags, last presence status and last read byte
// cfg port: 12-bit timing registers written by index; the user must write them
//   only while the master is idle, which the block itself does not enforce
// output: a request's result is registered and shows on out_if in the cycle
//   after acceptance; one request per cycle while in_if.ready is high
// reset: sequencer idle, status and read byte cleared, timing registers
//   return to their defaults, output register empty
// stall: a held result stays on out_if; in_if.ready drops only while the
//   output register is full and not being taken
module onewire_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  owm_in_if.sink                        in_if,
  owm_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [owm_pkg::TickW-1:0]     cfg_data_i
);
  import owm_pkg::*;

  cfg_t  cfg;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  in_ready;
  logic  accept;

  // output register can take a new result when empty or draining this cycle
  assign in_ready = !out_valid_q || out_if.ready;
  assign accept   = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  owm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer: advances one tick per accepted request
  owm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .command_i    (in_if.command),
    .data_byte_i  (in_if.data_byte),
    .line_level_i (in_if.line_level),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.drive_low       = out_q.drive_low;
  assign out_if.busy_res        = out_q.busy_res;
  assign out_if.done_res        = out_q.done_res;
  assign out_if.presence_status = out_q.presence_status;
  assign out_if.read_data       = out_q.read_data;

endmodule

// ----- src/owm_checker.sv -----
`include "assert_macros.svh"

module owm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        drive_low_i,
  input logic                        busy_res_i,
  input logic                        done_res_i,
  input logic [1:0]                  presence_status_i,
  input logic [owm_pkg::ByteW-1:0]   read_data_i
);
  import owm_pkg::*;

  // a stalled result holds
  `OWM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_low_i) && $stable(busy_res_i) && $stable(done_res_i) && $stable(presence_status_i) && $stable(read_data_i))

  // every accepted request produces a result next cycle
  `OWM_ASSERT(a_req_to_res, in_valid_i && in_ready_i |=> out_valid_i)

  // no new request while a result is stuck
  `OWM_ASSERT(a_backpressure, out_valid_i && !out_ready_i |-> !in_ready_i)

  // completion tick is never busy
  `OWM_ASSERT(a_done_not_busy, out_valid_i && done_res_i |-> !busy_res_i)

  // the bus is only pulled low in the middle of a command
  `OWM_ASSERT(a_drive_busy, out_valid_i && drive_low_i |-> busy_res_i)

endmodule

bind onewire_master owm_checker u_owm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .drive_low_i       (out_if.drive_low),
  .busy_res_i        (out_if.busy_res),
  .done_res_i        (out_if.done_res),
  .presence_status_i (out_if.presence_status),
  .read_data_i       (out_if.read_data)
);

// ----- tb/sv/onewire_master_tb.sv -----
`timescale 1ns / 100ps

module onewire_master_tb;
  import owm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_TICKS = 500;
  localparam int unsigned RANDOM_SETS  = 5;
  localparam int unsigned MAX_REPORTS  = 10;

  // sequencer phases of the bus master, as tracked on the bench side
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_REST, SEQ_RST_LOW, SEQ_PRES_WAIT, SEQ_PRES_END,
    SEQ_WR_LOW, SEQ_WR_REC, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REC
  } seq_phase_e;

  // tracks the bus sequencer tick by tick and holds the bus results still due
  class owm_tick_tracker;
    cfg_t               timing;
    seq_phase_e         phase;
    tick_t              tick_count;
    logic [BitIdxW-1:0] bit_index;
    logic [ByteW-1:0]   shift_byte;
    status_e            last_status;
    logic [ByteW-1:0]   last_read;
    res_t               bus_res_q[$];
    int unsigned        mismatches;

    function new();
      timing = '{REST_RST, RST_LOW_RST, PRES_WAIT_RST, PRES_END_RST,
                 WR_ONE_RST, WR_ZERO_RST, WR_REC_RST, RD_REC_RST};
      phase       = SEQ_IDLE;
      tick_count  = '0;
      bit_index   = '0;
      shift_byte  = '0;
      last_status = ST_PRESENT;
      last_read   = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, tick_t val);
      case (idx)
        REG_REST:      timing.rest_ticks           = val;
        REG_RST_LOW:   timing.reset_low_ticks      = val;
        REG_PRES_WAIT: timing.presence_wait_ticks  = val;
        REG_PRES_END:  timing.presence_end_ticks   = val;
        REG_WR_ONE:    timing.write_one_low_ticks  = val;
        REG_WR_ZERO:   timing.write_zero_low_ticks = val;
        REG_WR_REC:    timing.write_recovery_ticks = val;
        default:       timing.read_recovery_ticks  = val;
      endcase
    endfunction

    function void enter(seq_phase_e next_phase);
      phase      = next_phase;
      tick_count = '0;
    endfunction

    // advance one tick and queue the bus result it yields
    function void note_tick(cmd_e cmd, logic [ByteW-1:0] data, logic level);
      logic  drive;
      logic  done;
      tick_t slot;
      res_t  res;
      drive = 1'b0;
      done  = 1'b0;
      if (phase == SEQ_IDLE && cmd != CMD_NONE) begin
        bit_index = '0;
        case (cmd)
          CMD_RESET: enter(SEQ_REST);
          CMD_WRITE: begin
            shift_byte = data;
            enter(SEQ_WR_LOW);
          end
          default: begin
            shift_byte = '0;
            enter(SEQ_RD_LOW);
          end
        endcase
      end
      if (phase != SEQ_IDLE) begin
        drive = (phase == SEQ_RST_LOW) || (phase == SEQ_WR_LOW) || (phase == SEQ_RD_LOW);
        tick_count = tick_count + 1'b1;
        case (phase)
          SEQ_REST:      slot = timing.rest_ticks;
          SEQ_RST_LOW:   slot = timing.reset_low_ticks;
          SEQ_PRES_WAIT: slot = timing.presence_wait_ticks;
          SEQ_PRES_END:  slot = timing.presence_end_ticks;
          SEQ_WR_LOW:    slot = shift_byte[0] ? timing.write_one_low_ticks
                                              : timing.write_zero_low_ticks;
          SEQ_WR_REC:    slot = timing.write_recovery_ticks;
          SEQ_RD_LOW:    slot = READ_LOW_TICKS;
          SEQ_RD_WAIT:   slot = READ_SAMPLE_TICKS;
          SEQ_RD_REC:    slot = timing.read_recovery_ticks;
          default:       slot = tick_t'(1);
        endcase
        // a zero length still takes one tick
        if (slot == '0) slot = tick_t'(1);
        if (tick_count >= slot) begin
          case (phase)
            SEQ_REST: begin
              if (!level) begin
                last_status = ST_STUCK_LOW;
                done        = 1'b1;
              end else enter(SEQ_RST_LOW);
            end
            SEQ_RST_LOW: enter(SEQ_PRES_WAIT);
            SEQ_PRES_WAIT: begin
              if (level) begin
                last_status = ST_NO_PRESENCE;
                done        = 1'b1;
              end else enter(SEQ_PRES_END);
            end
            SEQ_PRES_END: begin
              last_status = level ? ST_PRESENT : ST_NOT_ENDED;
              done        = 1'b1;
            end
            SEQ_WR_LOW: enter(SEQ_WR_REC);
            SEQ_WR_REC: begin
              if (&bit_index) done = 1'b1;
              else begin
                shift_byte = shift_byte >> 1;
                bit_index  = bit_index + 1'b1;
                enter(SEQ_WR_LOW);
              end
            end
            SEQ_RD_LOW: enter(SEQ_RD_WAIT);
            SEQ_RD_WAIT: begin
              shift_byte = {level, shift_byte[ByteW-1:1]};
              enter(SEQ_RD_REC);
            end
            SEQ_RD_REC: begin
              if (&bit_index) begin
                last_read = shift_byte;
                done      = 1'b1;
              end else begin
                bit_index = bit_index + 1'b1;
                enter(SEQ_RD_LOW);
              end
            end
            default: done = 1'b1;
          endcase
          if (done) enter(SEQ_IDLE);
        end
      end
      res.drive_low       = drive;
      res.busy_res        = (phase != SEQ_IDLE);
      res.done_res        = done;
      res.presence_status = last_status;
      res.read_data       = last_read;
      bus_res_q.push_back(res);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (bus_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected bus result: drive %b busy %b done %b status %0d read %02h",
                   got.drive_low, got.busy_res, got.done_res, got.presence_status,
                   got.read_data);
        return;
      end
      want = bus_res_q.pop_front();
      if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res ||
          got.presence_status !== want.presence_status ||
          got.read_data !== want.read_data) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("bus result mismatch: expected drive %b busy %b done %b status %0d read %02h",
                 want.drive_low, want.busy_res, want.done_res, want.presence_status,
                 want.read_data);
          $display(", got drive %b busy %b done %b status %0d read %02h",
                   got.drive_low, got.busy_res, got.done_res,
                   got.presence_status, got.read_data);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  tick_t              cfg_data_i;

  owm_in_if  in_if();
  owm_out_if out_if();

  onewire_master dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  owm_tick_tracker tracker;

  // sender pacing and the behavior of the simulated slave
  int unsigned      ticks_sent;
  int unsigned      burst_left;
  int unsigned      gap_max;
  int unsigned      noise_pct;
  bit               in_valid_on;
  status_e          slave_plan;
  logic [ByteW-1:0] slave_byte;

  // receiver stall pattern
  int unsigned sink_mode;
  int unsigned mode_left;
  int unsigned stall_left;

  int unsigned cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: runs of always ready, random ready, and short stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else mode_left--;
      case (sink_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_if.ready <= 1'b0;
          end else out_if.ready <= 1'b1;
        end
      endcase
    end
  end

  // every taken result goes against the oldest one still due
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.drive_low       = out_if.drive_low;
      got.busy_res        = out_if.busy_res;
      got.done_res        = out_if.done_res;
      got.presence_status = out_if.presence_status;
      got.read_data       = out_if.read_data;
      tracker.check_result(got);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // line level the slave would show on this tick; only the last tick of
  // rest, presence wait, presence end and read sample is ever looked at
  function automatic logic slave_level(cmd_e cmd);
    seq_phase_e ph;
    ph = tracker.phase;
    if (ph == SEQ_IDLE && cmd == CMD_RESET) ph = SEQ_REST;
    if ($urandom_range(0, 99) < noise_pct) return 1'($urandom_range(0, 1));
    case (ph)
      SEQ_REST:      return slave_plan != ST_STUCK_LOW;
      SEQ_PRES_WAIT: return slave_plan == ST_NO_PRESENCE;
      SEQ_PRES_END:  return slave_plan != ST_NOT_ENDED;
      SEQ_RD_WAIT:   return slave_byte[tracker.bit_index];
      default:       return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // mostly short timings so the random part runs many commands
  function automatic tick_t rand_ticks(tick_t min_val);
    case ($urandom_range(0, 9))
      0:       return min_val;
      8:       return tick_t'($urandom_range(7, 40));
      9:       return tick_t'($urandom_range(41, 150));
      default: return tick_t'($urandom_range(1, 6));
    endcase
  endfunction

  // one tick request; valid stays up across a burst, then a random gap
  task automatic send_tick(cmd_e cmd, logic [ByteW-1:0] data, logic level);
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.data_byte  <= data;
    in_if.line_level <= level;
    in_valid_on = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_tick(cmd, data, level);
    ticks_sent++;
    if (gap_max == 0) return;
    if (burst_left > 0) burst_left--;
    else begin
      in_if.valid <= 1'b0;
      in_valid_on = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // hold off the sender until every bus result has come back
  task automatic wait_drained();
    if (in_valid_on) begin
      in_if.valid <= 1'b0;
      in_valid_on = 1'b0;
    end
    while (tracker.bus_res_q.size() != 0) @(posedge clk_i);
  endtask

  // write all eight timing registers, only with the master idle and drained
  task automatic program_timing(cfg_t c);
    tick_t vals[8];
    vals = '{c.rest_ticks, c.reset_low_ticks, c.presence_wait_ticks,
             c.presence_end_ticks, c.write_one_low_ticks, c.write_zero_low_ticks,
             c.write_recovery_ticks, c.read_recovery_ticks};
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // start one command and keep ticking until the master is idle again;
  // chatter throws ignored commands at the busy master
  task automatic run_command(cmd_e cmd, logic [ByteW-1:0] data, status_e plan,
                             logic [ByteW-1:0] sbyte, bit chatter, bit pause_mid);
    cmd_e        extra;
    int unsigned busy_ticks;
    slave_plan = plan;
    slave_byte = sbyte;
    busy_ticks = 0;
    send_tick(cmd, data, slave_level(cmd));
    while (tracker.phase != SEQ_IDLE) begin
      busy_ticks++;
      if (pause_mid && busy_ticks == 3) wait_drained();
      extra = (chatter && $urandom_range(0, 3) == 0) ? cmd_e'($urandom_range(1, 3))
                                                     : CMD_NONE;
      send_tick(extra, ByteW'($urandom), slave_level(extra));
    end
  endtask

  initial begin
    cfg_t        rand_cfg;
    int unsigned set_end;
    int unsigned pick;
    cmd_e        op;

    tracker = new();
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_REST;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_NONE;
    in_if.data_byte  = '0;
    in_if.line_level = 1'b1;
    out_if.ready     = 1'b0;
    ticks_sent  = 0;
    burst_left  = 0;
    gap_max     = 2;
    noise_pct   = 0;
    in_valid_on = 1'b0;
    slave_plan  = ST_PRESENT;
    slave_byte  = '0;
    sink_mode   = 0;
    mode_left   = 0;
    stall_left  = 0;
    cycle_count = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timing defaults: a write with one zero bit and seven one bits
    send_tick(CMD_NONE, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFE, ST_PRESENT, 8'h00, 1'b1, 1'b0);

    // shortest timings, zero lengths acting as one tick
    program_timing('{tick_t'(0), tick_t'(1), tick_t'(1), tick_t'(1),
                     tick_t'(1), tick_t'(1), tick_t'(0), tick_t'(0)});
    gap_max = 0;
    // every reset outcome, back to back
    run_command(CMD_RESET, 8'hFF, ST_STUCK_LOW, 8'h00, 1'b0, 1'b0);
    run_command(CMD_RESET, 8'h00, ST_NO_PRESENCE, 8'h00, 1'b1, 1'b0);
    run_command(CMD_RESET, 8'h00, ST_NOT_ENDED, 8'h00, 1'b0, 1'b0);
    run_command(CMD_RESET, 8'h00, ST_PRESENT, 8'h00, 1'b0, 1'b0);
    // single set bit at each end of the byte, a write leaves status alone
    run_command(CMD_WRITE, 8'h01, ST_PRESENT, 8'h00, 1'b1, 1'b0);
    run_command(CMD_WRITE, 8'h80, ST_PRESENT, 8'h00, 1'b0, 1'b0);
    send_tick(CMD_NONE, 8'hFF, 1'b1);
    send_tick(CMD_NONE, 8'h00, 1'b0);
    run_command(CMD_READ, 8'hFF, ST_PRESENT, 8'h00, 1'b0, 1'b0);
    run_command(CMD_READ, 8'h00, ST_PRESENT, 8'hFF, 1'b1, 1'b0);
    gap_max = 2;

    // random timing sets, each with a run of random commands
    for (int s = 0; s < RANDOM_SETS; s++) begin
      rand_cfg.rest_ticks           = rand_ticks(tick_t'(0));
      rand_cfg.reset_low_ticks      = rand_ticks(tick_t'(1));
      rand_cfg.presence_wait_ticks  = rand_ticks(tick_t'(1));
      rand_cfg.presence_end_ticks   = rand_ticks(tick_t'(1));
      rand_cfg.write_one_low_ticks  = rand_ticks(tick_t'(1));
      rand_cfg.write_zero_low_ticks = rand_ticks(tick_t'(1));
      rand_cfg.write_recovery_ticks = rand_ticks(tick_t'(0));
      rand_cfg.read_recovery_ticks  = rand_ticks(tick_t'(0));
      program_timing(rand_cfg);
      set_end = ticks_sent + RANDOM_TICKS / RANDOM_SETS;
      while (ticks_sent < set_end) begin
        gap_max   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        noise_pct = ($urandom_range(0, 7) == 0) ? 20 : 0;
        repeat ($urandom_range(0, 2))
          send_tick(CMD_NONE, ByteW'($urandom), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        op   = (pick < 3) ? CMD_RESET : (pick < 6) ? CMD_WRITE : CMD_READ;
        run_command(op, ByteW'($urandom), status_e'($urandom_range(0, 3)), ByteW'($urandom),
                    1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.bus_res_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/owm_pkg.sv
src/owm_if.sv
src/owm_cfg.sv
src/owm_core.sv
src/onewire_master.sv
src/owm_checker.sv
tb/sv/onewire_master_tb.sv
